FILE: rtl/tri_pkg.sv
`default_nettype none

package tri_pkg;

  // Port and field widths
  localparam int ORIGIN_W = 32;
  localparam int STEP_W   = 17;
  localparam int INDEX_W  = 24;
  localparam int COUNT_W  = 16;
  localparam int RESULT_W = 48;
  localparam int CFG_W    = 32;

  // Internal datapath widths
  localparam int IDX_W    = INDEX_W + 1;           // first index plus offset
  localparam int XPROD_W  = STEP_W + IDX_W;        // step times index
  localparam int XW_W     = XPROD_W + 2;           // signed x before range check
  localparam int SQ_W     = 64;                    // x squared and numerator
  localparam int NUM_W    = 63;                    // numerator magnitude
  localparam int DEN_W    = 32;                    // denominator, always positive
  localparam int SUM_W    = RESULT_W + 2;          // running trapezoid sum
  localparam int HALF_W   = RESULT_W / 2;          // multiplier split point
  localparam int PART_W   = HALF_W + STEP_W;       // one partial product
  localparam int PROD_W   = RESULT_W + STEP_W;     // full scaled product
  localparam int DCNT_W   = $clog2(NUM_W + 1);     // divider iteration count

  localparam logic [STEP_W-1:0] STEP_RESET = 17'd655;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_ORIGIN = 1'b0,
    REG_STEP   = 1'b1
  } cfg_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic calc_x;
    logic square;
    logic div_start;
    logic accum;
    logic scale_lo;
    logic scale_hi;
    logic round;
  } tri_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic point_bad;
    logic div_last;
    logic acc_bad;
    logic last_point;
  } tri_status_t;

endpackage

`default_nettype wire

FILE: rtl/tri_div.sv
`default_nettype none

module tri_div
  import tri_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic      [NUM_W-1:0] quotient,
  output logic                  last
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [DEN_W:0]    sh;
  logic              ge;
  logic [DEN_W:0]    diff;

  // Trial subtract of one quotient bit
  always_comb begin
    sh   = {rem, quo[NUM_W-1]};
    ge   = sh >= {1'b0, dsr};
    diff = sh - {1'b0, dsr};
  end

  assign last     = busy && (cnt == DCNT_W'(1));
  assign quotient = quo;

  // Shift the dividend out and the quotient in, one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DCNT_W'(NUM_W);
      quo  <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      quo  <= {quo[NUM_W-2:0], ge};
      cnt  <= cnt - DCNT_W'(1);
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tri_dpath.sv
`default_nettype none

module tri_dpath
  import tri_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tri_cmd_t                   cmd,
  input  wire logic [INDEX_W-1:0]         first_index,
  input  wire logic [COUNT_W-1:0]         interval_count,
  input  wire logic signed [ORIGIN_W-1:0] origin,
  input  wire logic [STEP_W-1:0]          step_size,
  output tri_status_t                     status,
  output logic [RESULT_W-1:0]             res_integral,
  output logic                            res_error
);

  localparam int CNT_EFF = (COUNT_WIDTH < COUNT_W) ? COUNT_WIDTH : COUNT_W;
  localparam logic [COUNT_W-1:0] CNT_MASK =
    COUNT_W'((33'(1) << CNT_EFF) - 33'(1));
  localparam logic signed [XW_W-1:0] FOUR_X  = XW_W'(4) << FRAC_BITS;
  localparam logic signed [XW_W-1:0] X_MAX   = XW_W'(32'h7FFF_FFFF);
  localparam logic signed [XW_W-1:0] X_MIN   = -X_MAX - XW_W'(1);
  localparam logic signed [SQ_W-1:0] TWO_Q   = SQ_W'(2) << (2 * FRAC_BITS);
  localparam logic [NUM_W-1:0]       F_MAX   = NUM_W'(48'h7FFF_FFFF_FFFF);
  localparam logic signed [SUM_W-1:0] S_MAX  = SUM_W'(48'h7FFF_FFFF_FFFF);
  localparam logic signed [SUM_W-1:0] S_MIN  = -S_MAX - SUM_W'(1);
  localparam logic [PROD_W-1:0]      Q_MAX   = PROD_W'(48'h7FFF_FFFF_FFFF);
  localparam logic [PROD_W-1:0]      R_MASK  =
    PROD_W'((PROD_W'(1) << FRAC_BITS) - PROD_W'(1));

  logic [INDEX_W-1:0]        first_r;
  logic [COUNT_W-1:0]        n_r;
  logic [COUNT_W-1:0]        seq;
  logic signed [XW_W-1:0]    xw;
  logic signed [SQ_W-1:0]    sq;
  logic [DEN_W-1:0]          den;
  logic                      num_neg;
  logic signed [SUM_W-1:0]   sum;
  logic                      err;
  logic [PART_W-1:0]         p_lo;
  logic [HALF_W-1:0]         mag_hi;
  logic                      neg_r;
  logic [PROD_W-1:0]         prod;

  logic [COUNT_W-1:0]        offset;
  logic [IDX_W-1:0]          idx;
  logic [XPROD_W-1:0]        prod_x;
  logic signed [XW_W-1:0]    xw_next;
  logic signed [XW_W-1:0]    den_full;
  logic signed [ORIGIN_W-1:0] x32;
  logic signed [SQ_W-1:0]    num;
  logic [SQ_W-1:0]           num_mag;
  logic [NUM_W-1:0]          quo;
  logic                      div_last;
  logic                      fits_f;
  logic signed [SUM_W-1:0]   f_val;
  logic signed [SUM_W-1:0]   sum_add;
  logic                      sum_fits;
  logic [SUM_W-1:0]          sum_mag;
  logic [PART_W-1:0]         p_hi;
  logic [PROD_W-1:0]         q_sh;
  logic [PROD_W-1:0]         q_rnd;
  logic                      over;

  // Point index: first end, last end, then the interior points in order
  always_comb begin
    if (seq == '0) begin
      offset = '0;
    end else if (seq == COUNT_W'(1)) begin
      offset = n_r;
    end else begin
      offset = seq - COUNT_W'(1);
    end
    idx     = IDX_W'(first_r) + IDX_W'(offset);
    prod_x  = XPROD_W'(step_size) * XPROD_W'(idx);
    xw_next = XW_W'(origin) + $signed(XW_W'(prod_x));
  end

  // Range and pole checks, numerator and denominator
  always_comb begin
    den_full = xw + FOUR_X;
    x32      = xw[ORIGIN_W-1:0];
    num      = TWO_Q - sq;
    num_mag  = num[SQ_W-1] ? SQ_W'(-num) : SQ_W'(num);
  end

  assign status.point_bad = (xw > X_MAX) || (xw < X_MIN) ||
                            den_full[XW_W-1] || (den_full == '0);

  tri_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num_mag[NUM_W-1:0]),
    .divisor  (den),
    .quotient (quo),
    .last     (div_last)
  );

  assign status.div_last = div_last;

  // Signed point value and running sum
  always_comb begin
    fits_f   = num_neg ? (quo <= F_MAX + NUM_W'(1)) : (quo <= F_MAX);
    f_val    = num_neg ? -$signed(quo[SUM_W-1:0]) : $signed(quo[SUM_W-1:0]);
    sum_add  = sum + f_val;
    sum_fits = (sum_add <= S_MAX) && (sum_add >= S_MIN);
  end

  assign status.acc_bad    = !fits_f || ((seq[COUNT_W-1:1] != '0) && !sum_fits);
  assign status.last_point = (seq == ((n_r == '0) ? COUNT_W'(1) : n_r));

  // Scale by the step in two partial products, then round down
  always_comb begin
    sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    p_hi    = PART_W'(mag_hi) * PART_W'(step_size);
    q_sh    = prod >> FRAC_BITS;
    q_rnd   = q_sh + PROD_W'(neg_r && ((prod & R_MASK) != '0));
    over    = neg_r ? (q_rnd > Q_MAX + PROD_W'(1)) : (q_rnd > Q_MAX);
  end

  // Error flag
  always_ff @(posedge clk) begin
    if (rst) begin
      err <= 1'b0;
    end else if (cmd.load) begin
      err <= 1'b0;
    end else if ((cmd.square && status.point_bad) ||
                 (cmd.accum && status.acc_bad)) begin
      err <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= first_index;
      n_r     <= interval_count & CNT_MASK;
      seq     <= '0;
      sum     <= '0;
    end
    if (cmd.calc_x) begin
      xw <= xw_next;
    end
    if (cmd.square) begin
      sq  <= SQ_W'(x32) * SQ_W'(x32);
      den <= den_full[DEN_W-1:0];
    end
    if (cmd.div_start) begin
      num_neg <= num[SQ_W-1];
    end
    if (cmd.accum) begin
      seq <= seq + COUNT_W'(1);
      if (seq == '0) begin
        sum <= f_val;
      end else if (seq == COUNT_W'(1)) begin
        sum <= sum_add >>> 1;
      end else begin
        sum <= sum_add;
      end
    end
    if (cmd.scale_lo) begin
      neg_r  <= sum[SUM_W-1];
      mag_hi <= sum_mag[RESULT_W-1:HALF_W];
      p_lo   <= PART_W'(sum_mag[HALF_W-1:0]) * PART_W'(step_size);
    end
    if (cmd.scale_hi) begin
      prod <= PROD_W'(p_lo) + (PROD_W'(p_hi) << HALF_W);
    end
    if (cmd.round) begin
      res_error <= err || over;
      if (err || over) begin
        res_integral <= '0;
      end else if (neg_r) begin
        res_integral <= RESULT_W'(-q_rnd);
      end else begin
        res_integral <= q_rnd[RESULT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tri_ctrl.sv
`default_nettype none

module tri_ctrl
  import tri_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        slot_free,
  input  wire tri_status_t status,
  output tri_cmd_t         cmd,
  output logic             in_ready,
  output logic             emit
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_XCALC    = 10'b00_0000_0010,
    S_SQUARE   = 10'b00_0000_0100,
    S_DSTART   = 10'b00_0000_1000,
    S_DIVIDE   = 10'b00_0001_0000,
    S_ACCUM    = 10'b00_0010_0000,
    S_SCALE_LO = 10'b00_0100_0000,
    S_SCALE_HI = 10'b00_1000_0000,
    S_ROUND    = 10'b01_0000_0000,
    S_EMIT     = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    emit       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_XCALC;
        end
      end
      S_XCALC: begin
        cmd.calc_x = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = status.point_bad ? S_ROUND : S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (status.div_last) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        if (status.acc_bad) begin
          state_next = S_ROUND;
        end else if (status.last_point) begin
          state_next = S_SCALE_LO;
        end else begin
          state_next = S_XCALC;
        end
      end
      S_SCALE_LO: begin
        cmd.scale_lo = 1'b1;
        state_next   = S_SCALE_HI;
      end
      S_SCALE_HI: begin
        cmd.scale_hi = 1'b1;
        state_next   = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trapezoid_rational_integrator.sv
// Trapezoidal integral of f(x) = (2 - x*x) / (4 + x) over a span of
// subintervals, in signed fixed point with FRAC_BITS fraction bits. One
// request at a time: a request with count n evaluates max(n+1, 2) points
// (both ends first, then the interior). Each point runs the x, square,
// divider load, divide and accumulate steps; the divider makes one quotient
// bit per cycle over 63 iterations. A point fault or a point or sum overflow
// ends a request early; that, or an overflow in the final scaling, sets
// domain_error and zeroes the integral. The result sits in an output
// register, so the next request is taken while it waits to be read.
`default_nettype none

module trapezoid_rational_integrator
  import tri_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [INDEX_W-1:0]  first_index,
  input  wire logic [COUNT_W-1:0]  interval_count,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [RESULT_W-1:0]      integral,
  output logic                     domain_error,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  logic signed [ORIGIN_W-1:0] origin;
  logic [STEP_W-1:0]          step_size;
  tri_cmd_t                   cmd;
  tri_status_t                status;
  logic                       emit;
  logic                       slot_free;
  logic [RESULT_W-1:0]        res_integral;
  logic                       res_error;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin    <= '0;
      step_size <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ORIGIN) begin
        origin <= cfg_data[ORIGIN_W-1:0];
      end else begin
        step_size <= cfg_data[STEP_W-1:0];
      end
    end
  end

  tri_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .slot_free (slot_free),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .emit      (emit)
  );

  tri_dpath #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .first_index    (first_index),
    .interval_count (interval_count),
    .origin         (origin),
    .step_size      (step_size),
    .status         (status),
    .res_integral   (res_integral),
    .res_error      (res_error)
  );

  // Output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      integral     <= res_integral;
      domain_error <= res_error;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && domain_error |-> integral == '0)
    else $error("faulted result carries a nonzero integral");

  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> in_valid && in_ready)
    else $error("request loaded without a handshake");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while one is in work");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("result overwrote a waiting result");

endmodule

`default_nettype wire

FILE: bench/trapezoid_rational_integrator_checker.sv
`timescale 1ns / 100ps

module trapezoid_rational_integrator_checker
  import tri_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic [INDEX_W-1:0]  first_index,
  input  wire logic [COUNT_W-1:0]  interval_count,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [RESULT_W-1:0] integral,
  input  wire logic                domain_error,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  output int                       fail_count,
  output int                       pending,
  output int                       results_seen,
  output int                       faults_seen
);

  localparam int FB = 16;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct {
    logic [RESULT_W-1:0] integral;
    logic                fault;
  } integral_t;

  integral_t expected_q[$];

  // configuration copy, tracked from the register channel
  longint               x_origin;
  logic [STEP_W-1:0]    x_step;

  function automatic bit in48(longint v);
    return v >= SUM_MIN && v <= SUM_MAX;
  endfunction

  // evaluate f at one point index; returns 0 on a fault
  function automatic bit f_at(longint idx, output longint val);
    longint x, den, num;
    x = x_origin + longint'(x_step) * idx;
    val = 0;
    if (x > 64'sd2147483647 || x < -64'sd2147483648) return 0;
    den = x + (64'sd4 <<< FB);
    if (den <= 0) return 0;
    num = (64'sd2 <<< (2 * FB)) - x * x;
    val = num / den;
    return in48(val);
  endfunction

  function automatic integral_t integrate(longint first, longint n);
    integral_t r;
    longint fa, fb, fi, sum;
    logic [63:0] mag, prod, q;
    bit bad, neg;
    bad = 0;
    sum = 0;
    if (!f_at(first, fa) || !f_at(first + n, fb)) begin
      bad = 1;
    end else begin
      sum = (fa + fb) >>> 1;
      for (longint i = 1; i < n; i++) begin
        if (!f_at(first + i, fi)) begin
          bad = 1;
          break;
        end
        sum += fi;
        if (!in48(sum)) begin
          bad = 1;
          break;
        end
      end
    end
    r.integral = '0;
    if (!bad) begin
      neg = sum < 0;
      mag = neg ? 64'd0 - 64'(sum) : 64'(sum);
      prod = mag * 64'(x_step);
      q = prod >> FB;
      if (neg && prod[FB-1:0] != 0) q += 1;
      if (!neg && q > 64'(SUM_MAX)) bad = 1;
      else if (neg && q > 64'(SUM_MAX) + 1) bad = 1;
      else r.integral = neg ? RESULT_W'(-longint'(q)) : RESULT_W'(q);
    end
    if (bad) r.integral = '0;
    r.fault = bad;
    return r;
  endfunction

  always @(posedge clk) begin
    integral_t e;
    if (rst) begin
      x_origin = 0;
      x_step = STEP_RESET;
      expected_q.delete();
      fail_count = 0;
      results_seen = 0;
      faults_seen = 0;
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ORIGIN) x_origin = longint'($signed(cfg_data));
        else x_step = cfg_data[STEP_W-1:0];
      end
      // predict each accepted request
      if (in_valid && in_ready)
        expected_q.push_back(integrate(longint'(first_index), longint'(interval_count)));
      // compare each accepted result with the oldest prediction
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result integral=%h domain_error=%b",
                   $time, integral, domain_error);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (e.fault) faults_seen++;
          if (e.integral !== integral) begin
            $display("%0t: integral expected %h actual %h", $time, e.integral, integral);
            fail_count++;
          end
          if (e.fault !== domain_error) begin
            $display("%0t: domain_error expected %b actual %b",
                     $time, e.fault, domain_error);
            fail_count++;
          end
        end
      end
    end
    // requests still waiting for their result
    pending = expected_q.size();
  end

endmodule

FILE: bench/trapezoid_rational_integrator_tb.sv
`timescale 1ns / 100ps

module trapezoid_rational_integrator_tb;
  import tri_pkg::*;

  logic                clk = 0;
  logic                rst = 1;
  logic                in_valid = 0;
  logic                in_ready;
  logic [INDEX_W-1:0]  first_index = '0;
  logic [COUNT_W-1:0]  interval_count = '0;
  logic                out_valid;
  logic                out_ready = 0;
  logic [RESULT_W-1:0] integral;
  logic                domain_error;
  logic                cfg_valid = 0;
  logic                cfg_ready;
  logic [0:0]          cfg_index = REG_ORIGIN;
  logic [CFG_W-1:0]    cfg_data = '0;

  int  fail_count, pending, results_seen, faults_seen;
  int  requests_sent = 0;
  bit  sender_quiet = 0;
  longint cur_origin = 0;
  longint cur_step = 655;

  trapezoid_rational_integrator uut (
    .clk, .rst, .in_valid, .in_ready, .first_index, .interval_count,
    .out_valid, .out_ready, .integral, .domain_error,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  trapezoid_rational_integrator_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .first_index, .interval_count,
    .out_valid, .out_ready, .integral, .domain_error,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .results_seen, .faults_seen
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // abort a hung run
  initial begin
    #40_000_000;
    $display("FAIL trapezoid_rational_integrator");
    $finish;
  end

  // drain results with random stalls, quiet stretches and one long hold
  initial begin
    int stall, quiet_left, taken;
    quiet_left = 0;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == 30) begin
        out_ready = 0;
        repeat (3000) @(negedge clk);
      end
      if (quiet_left > 0) begin
        quiet_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 5);
        if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(5, 20);
      end
      out_ready = 0;
      repeat (stall) @(negedge clk);
      out_ready = 1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
      @(negedge clk);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid = 0;
    if (idx == REG_ORIGIN) cur_origin = longint'($signed(value));
    else cur_step = longint'(value[STEP_W-1:0]);
  endtask

  // wait for the block to go idle, then load both registers
  task automatic set_span(logic [CFG_W-1:0] org, logic [CFG_W-1:0] stp);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    write_reg(REG_ORIGIN, org);
    write_reg(REG_STEP, stp);
  endtask

  function automatic bit point_ok(longint idx);
    longint x;
    x = cur_origin + cur_step * idx;
    return x <= 64'sd2147483647 && x >= -64'sd2147483648 && x > -(64'sd4 <<< 16);
  endfunction

  task automatic send_request(logic [INDEX_W-1:0] first, logic [COUNT_W-1:0] cnt);
    int gap;
    // trim long spans whose ends are valid, so the run stays short
    if (cnt > 64 && point_ok(first) && point_ok(longint'(first) + cnt)) cnt = cnt & 16'h3F;
    gap = sender_quiet ? 0 : $urandom_range(0, 5);
    repeat (gap) @(negedge clk);
    first_index = first;
    interval_count = cnt;
    in_valid = 1;
    do @(posedge clk); while (!(in_valid && in_ready));
    requests_sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)
      send_request(INDEX_W'($urandom_range(0, 200)),
                   COUNT_W'(pick == 0 ? $urandom_range(0, 63) : $urandom_range(0, 12)));
    else
      send_request(INDEX_W'($urandom), COUNT_W'($urandom));
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 0;

    // reset values, plain spans
    set_span(32'd0, 32'd655);
    send_request(0, 0);
    send_request(0, 1);
    send_request(0, 2);
    send_request(100, 10);
    send_request(24'hFFFFFF, 0);
    send_request(24'h555555, 16'hAAAA);

    // pole at the first point, then just right of it
    set_span(32'hFFFC_0000, 32'd65536);
    send_request(0, 3);
    send_request(1, 3);

    // most negative origin, step of 1.0
    set_span(32'h8000_0000, 32'd65536);
    send_request(0, 16'hFFFF);
    send_request(24'hFFFFFF, 0);
    send_request(24'h8000, 2);

    // largest origin, smallest nonzero step: second point leaves the x range
    set_span(32'h7FFF_FFFF, 32'd1);
    send_request(0, 0);
    send_request(1, 0);
    send_request(0, 1);

    // zero step: every point sits at the origin
    set_span(32'hFFFD_0000, 32'd0);
    send_request(5, 4);

    // largest step the 17-bit step register holds
    set_span(32'd0, 32'h1FFFF);
    send_request(0, 5);
    send_request(3, 16'hFFFF);

    // random phases with random register settings
    for (int ph = 0; ph < 6; ph++) begin
      set_span(CFG_W'($urandom_range(0, 6 << 16)) - CFG_W'(3 << 16),
               ph == 5 ? CFG_W'($urandom) : CFG_W'($urandom_range(1, ph < 3 ? 4096 : 65536)));
      sender_quiet = (ph % 3 == 1);
      for (int k = 0; k < 17; k++) random_request();
    end

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Sent %0d requests across 12 register settings; %0d results, %0d faulted.",
             requests_sent, results_seen, faults_seen);
    if (fail_count == 0)
      $display("PASS trapezoid_rational_integrator");
    else
      $display("FAIL trapezoid_rational_integrator");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tri_pkg.sv
rtl/tri_div.sv
rtl/tri_dpath.sv
rtl/tri_ctrl.sv
rtl/trapezoid_rational_integrator.sv
bench/trapezoid_rational_integrator_checker.sv
bench/trapezoid_rational_integrator_tb.sv
